>>> hw/rtl/alu_nzcv_pkg.sv
// Package: widths, opcodes, condition codes and flag helpers for the NZCV ALU.
`default_nettype none
package alu_nzcv_pkg;

  localparam int DATA_W  = 64;
  localparam int OP_W    = 4;
  localparam int SHIFT_W = 6;
  localparam int COND_W  = 4;
  localparam int FLAG_W  = 4;

  localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
  localparam logic [OP_W-1:0] OP_ORN   = 4'd2;
  localparam logic [OP_W-1:0] OP_OR    = 4'd3;
  localparam logic [OP_W-1:0] OP_XOR   = 4'd4;
  localparam logic [OP_W-1:0] OP_AND   = 4'd5;
  localparam logic [OP_W-1:0] OP_MOVW  = 4'd6;
  localparam logic [OP_W-1:0] OP_LSL   = 4'd7;
  localparam logic [OP_W-1:0] OP_LSR   = 4'd8;
  localparam logic [OP_W-1:0] OP_ASR   = 4'd9;
  localparam logic [OP_W-1:0] OP_PASSA = 4'd10;

  localparam logic [COND_W-1:0] COND_EQ = 4'd0;
  localparam logic [COND_W-1:0] COND_NE = 4'd1;
  localparam logic [COND_W-1:0] COND_CS = 4'd2;
  localparam logic [COND_W-1:0] COND_CC = 4'd3;
  localparam logic [COND_W-1:0] COND_MI = 4'd4;
  localparam logic [COND_W-1:0] COND_PL = 4'd5;
  localparam logic [COND_W-1:0] COND_VS = 4'd6;
  localparam logic [COND_W-1:0] COND_VC = 4'd7;
  localparam logic [COND_W-1:0] COND_HI = 4'd8;
  localparam logic [COND_W-1:0] COND_LS = 4'd9;
  localparam logic [COND_W-1:0] COND_GE = 4'd10;
  localparam logic [COND_W-1:0] COND_LT = 4'd11;
  localparam logic [COND_W-1:0] COND_GT = 4'd12;
  localparam logic [COND_W-1:0] COND_LE = 4'd13;

  localparam int FLAG_N_BIT = 3;
  localparam int FLAG_Z_BIT = 2;
  localparam int FLAG_C_BIT = 1;
  localparam int FLAG_V_BIT = 0;

  typedef logic [FLAG_W-1:0] flags_t;

  function automatic logic cond_pass(logic [COND_W-1:0] code, flags_t f);
    logic n;
    logic z;
    logic c;
    logic v;
    logic hold;
    n = f[FLAG_N_BIT];
    z = f[FLAG_Z_BIT];
    c = f[FLAG_C_BIT];
    v = f[FLAG_V_BIT];
    case (code)
      COND_EQ: hold = z;
      COND_NE: hold = !z;
      COND_CS: hold = c;
      COND_CC: hold = !c;
      COND_MI: hold = n;
      COND_PL: hold = !n;
      COND_VS: hold = v;
      COND_VC: hold = !v;
      COND_HI: hold = c && !z;
      COND_LS: hold = !c || z;
      COND_GE: hold = (n == v);
      COND_LT: hold = (n != v);
      COND_GT: hold = !z && (n == v);
      COND_LE: hold = z || (n != v);
      default: hold = 1'b1;
    endcase
    return hold;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/alu_nzcv_in_if.sv
// Interface: operation request channel of the NZCV ALU.
`default_nettype none
interface alu_nzcv_in_if;
  import alu_nzcv_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [DATA_W-1:0]  operand_a;
  logic [DATA_W-1:0]  operand_b;
  logic [SHIFT_W-1:0] wide_shift;
  logic               update_flags;
  logic [COND_W-1:0]  condition;

  modport source (
    output valid, opcode, operand_a, operand_b, wide_shift, update_flags, condition,
    input  ready
  );
  modport sink (
    input  valid, opcode, operand_a, operand_b, wide_shift, update_flags, condition,
    output ready
  );
endinterface
`default_nettype wire

>>> hw/rtl/alu_nzcv_out_if.sv
// Interface: result channel of the NZCV ALU.
`default_nettype none
interface alu_nzcv_out_if;
  import alu_nzcv_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result;
  logic              condition_true;
  logic [FLAG_W-1:0] flags_out;

  modport source (
    output valid, result, condition_true, flags_out,
    input  ready
  );
  modport sink (
    input  valid, result, condition_true, flags_out,
    output ready
  );
endinterface
`default_nettype wire

>>> hw/rtl/alu_with_nzcv_flags_and_condition_unit.sv
// Top level: 64-bit ALU with NZCV flag register and condition check.
//
// One beat in, one beat out. Every operation is computed in a single pass of
// logic between the request port and the result register, so the block takes a
// new beat every cycle while the result side does not stall, and each result
// appears in the cycle after its request is taken. The NZCV register is written
// at the same edge, so the next beat already sees the new flags. The request side
// stays ready while the result register is empty or being drained in the same
// cycle. Opcodes 11 to 15 return zero and never touch the flags.
`default_nettype none
module alu_with_nzcv_flags_and_condition_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  alu_nzcv_in_if.sink          req,
  alu_nzcv_out_if.source       rsp
);
  import alu_nzcv_pkg::*;

  logic                accept;
  logic                op_known;
  logic [DATA_W-1:0]   res;
  logic                c_bit;
  logic                v_bit;
  logic [SHIFT_W-1:0]  sh;
  logic [DATA_W:0]     sum;
  logic [DATA_W:0]     diff;
  logic [DATA_W:0]     lsl_wide;
  logic [DATA_W:0]     lsr_wide;
  logic [DATA_W:0]     asr_wide;
  flags_t              flags;
  flags_t              flags_next;

  logic                out_valid;
  logic [DATA_W-1:0]   out_result;
  logic                out_cond;
  flags_t              out_flags;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign sh       = req.operand_b[SHIFT_W-1:0];
  assign sum      = {1'b0, req.operand_a} + {1'b0, req.operand_b};
  assign diff     = {1'b0, req.operand_a} + {1'b0, ~req.operand_b} + {{DATA_W{1'b0}}, 1'b1};
  assign lsl_wide = {1'b0, req.operand_a} << sh;
  assign lsr_wide = {req.operand_a, 1'b0} >> sh;
  assign asr_wide = $unsigned($signed({req.operand_a, 1'b0}) >>> sh);

  always_comb begin
    res      = '0;
    c_bit    = 1'b0;
    v_bit    = 1'b0;
    op_known = 1'b1;
    case (req.opcode)
      OP_ADD: begin
        res   = sum[DATA_W-1:0];
        c_bit = sum[DATA_W];
        v_bit = (req.operand_a[DATA_W-1] ^ res[DATA_W-1])
              & (req.operand_b[DATA_W-1] ^ res[DATA_W-1]);
      end
      OP_SUB: begin
        res   = diff[DATA_W-1:0];
        c_bit = diff[DATA_W];
        v_bit = (req.operand_a[DATA_W-1] ^ req.operand_b[DATA_W-1])
              & (req.operand_a[DATA_W-1] ^ res[DATA_W-1]);
      end
      OP_ORN:   res = req.operand_a | ~req.operand_b;
      OP_OR:    res = req.operand_a | req.operand_b;
      OP_XOR:   res = req.operand_a ^ req.operand_b;
      OP_AND:   res = req.operand_a & req.operand_b;
      OP_MOVW:  res = req.operand_a | (req.operand_b << req.wide_shift);
      OP_LSL: begin
        res   = lsl_wide[DATA_W-1:0];
        c_bit = lsl_wide[DATA_W];
      end
      OP_LSR: begin
        res   = lsr_wide[DATA_W:1];
        c_bit = lsr_wide[0];
      end
      OP_ASR: begin
        res   = asr_wide[DATA_W:1];
        c_bit = asr_wide[0];
      end
      OP_PASSA: res = req.operand_a;
      default:  op_known = 1'b0;
    endcase
  end

  always_comb begin
    flags_next = flags;
    if (req.update_flags && op_known) begin
      flags_next[FLAG_N_BIT] = res[DATA_W-1];
      flags_next[FLAG_Z_BIT] = (res == '0);
      flags_next[FLAG_C_BIT] = c_bit;
      flags_next[FLAG_V_BIT] = v_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        flags     <= flags_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_result <= res;
      out_cond   <= cond_pass(req.condition, flags_next);
      out_flags  <= flags_next;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.result         = out_result;
  assign rsp.condition_true = out_cond;
  assign rsp.flags_out      = out_flags;

  a_flags_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> flags == $past(flags))
    else $error("flags changed without a beat");

  a_beat_shows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("accepted beat produced no result");

  a_out_flags: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.flags_out == flags)
    else $error("result flags differ from flag register");

  a_unknown_op: assert property (@(posedge clk) disable iff (rst)
    accept && !op_known |=> flags == $past(flags) && rsp.result == '0)
    else $error("unused opcode touched flags or result");

endmodule
`default_nettype wire

>>> tb/tb_alu_nzcv_checker.sv
// Checker: predicts each NZCV ALU response from the request beats and compares it.
`timescale 1ns / 1ps
module tb_alu_nzcv_checker (
  input  logic    clk,
  input  logic    rst,
  alu_nzcv_in_if  req,
  alu_nzcv_out_if rsp,
  output int      fail_count,
  output int      pending
);
  import alu_nzcv_pkg::*;

  typedef struct packed {
    logic              known;
    logic [DATA_W-1:0] value;
    logic              carry;
    logic              ovf;
  } alu_calc_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic              cond_true;
    flags_t            flags;
  } alu_beat_t;

  flags_t    nzcv;
  alu_beat_t expected_q[$];

  function automatic alu_calc_t alu_calc(logic [OP_W-1:0] op, logic [DATA_W-1:0] a,
                                         logic [DATA_W-1:0] b, logic [SHIFT_W-1:0] ws);
    alu_calc_t          r;
    logic [SHIFT_W-1:0] amt;
    r = '0;
    r.known = 1'b1;
    amt = b[SHIFT_W-1:0];
    case (op)
      OP_ADD: begin
        {r.carry, r.value} = {1'b0, a} + {1'b0, b};
        r.ovf = (a[DATA_W-1] == b[DATA_W-1]) && (r.value[DATA_W-1] != a[DATA_W-1]);
      end
      OP_SUB: begin
        r.value = a - b;
        r.carry = (a >= b);
        r.ovf = (a[DATA_W-1] != b[DATA_W-1]) && (r.value[DATA_W-1] != a[DATA_W-1]);
      end
      OP_ORN:   r.value = a | ~b;
      OP_OR:    r.value = a | b;
      OP_XOR:   r.value = a ^ b;
      OP_AND:   r.value = a & b;
      OP_MOVW:  r.value = a | (b << ws);
      OP_LSL: begin
        r.value = a << amt;
        if (amt != 0) r.carry = a[DATA_W - amt];
      end
      OP_LSR: begin
        r.value = a >> amt;
        if (amt != 0) r.carry = a[amt - 1];
      end
      OP_ASR: begin
        r.value = $signed(a) >>> amt;
        if (amt != 0) r.carry = a[amt - 1];
      end
      OP_PASSA: r.value = a;
      default:  r.known = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic cond_met(logic [COND_W-1:0] code, flags_t f);
    logic n;
    logic z;
    logic c;
    logic v;
    n = f[FLAG_N_BIT];
    z = f[FLAG_Z_BIT];
    c = f[FLAG_C_BIT];
    v = f[FLAG_V_BIT];
    case (code)
      COND_EQ: return z;
      COND_NE: return !z;
      COND_CS: return c;
      COND_CC: return !c;
      COND_MI: return n;
      COND_PL: return !n;
      COND_VS: return v;
      COND_VC: return !v;
      COND_HI: return c && !z;
      COND_LS: return !c || z;
      COND_GE: return n == v;
      COND_LT: return n != v;
      COND_GT: return !z && (n == v);
      COND_LE: return z || (n != v);
      default: return 1'b1;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    alu_calc_t calc;
    alu_beat_t want;
    if (rst) begin
      nzcv = '0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("%0t: response beat with none expected: result=%h", $realtime,
                     rsp.result);
          end
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (rsp.result !== want.result || rsp.condition_true !== want.cond_true ||
              rsp.flags_out !== want.flags) begin
            if (fail_count < 10) begin
              $display("%0t: mismatch result exp=%h got=%h cond exp=%b got=%b nzcv exp=%b got=%b",
                       $realtime, want.result, rsp.result, want.cond_true,
                       rsp.condition_true, want.flags, rsp.flags_out);
            end
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        calc = alu_calc(req.opcode, req.operand_a, req.operand_b, req.wide_shift);
        if (req.update_flags && calc.known) begin
          nzcv[FLAG_N_BIT] = calc.value[DATA_W-1];
          nzcv[FLAG_Z_BIT] = (calc.value == '0);
          nzcv[FLAG_C_BIT] = calc.carry;
          nzcv[FLAG_V_BIT] = calc.ovf;
        end
        want.result = calc.value;
        want.flags = nzcv;
        want.cond_true = cond_met(req.condition, nzcv);
        expected_q.push_back(want);
      end
    end
    pending = expected_q.size();
  end

endmodule

>>> tb/tb_alu_with_nzcv_flags_and_condition_unit.sv
// Testbench top: drives directed and random ALU operations and reports the verdict.
`timescale 1ns / 1ps
module tb_alu_with_nzcv_flags_and_condition_unit;
  import alu_nzcv_pkg::*;

  localparam logic [COND_W-1:0] COND_AL = 4'd14;
  localparam logic [COND_W-1:0] COND_NV = 4'd15;
  localparam logic [OP_W-1:0]   OP_UNUSED_LO = 4'd11;
  localparam logic [OP_W-1:0]   OP_UNUSED_HI = 4'd15;
  localparam logic [DATA_W-1:0] MIN_WORD = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] MAX_POS  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] ONES     = '1;
  localparam int RAND_PER_PHASE = 360;

  logic clk = 1'b0;
  logic rst;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   fail_count;
  int   pending;

  alu_nzcv_in_if  req ();
  alu_nzcv_out_if rsp ();

  alu_with_nzcv_flags_and_condition_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  tb_alu_nzcv_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] a,
                         input logic [DATA_W-1:0] b, input logic [SHIFT_W-1:0] ws,
                         input logic upd, input logic [COND_W-1:0] cond);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.opcode       <= op;
    req.operand_a    <= a;
    req.operand_b    <= b;
    req.wide_shift   <= ws;
    req.update_flags <= upd;
    req.condition    <= cond;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ONES;
      2:       return MIN_WORD;
      3:       return MAX_POS;
      4:       return DATA_W'($urandom_range(255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random();
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    if ($urandom_range(19) == 0) begin
      op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    end else begin
      op = OP_W'($urandom_range(OP_PASSA, OP_ADD));
    end
    a = rand_word();
    b = rand_word();
    case ($urandom_range(9))
      0:       b = a;
      1:       b = -a;
      2:       b[SHIFT_W-1:0] = '0;
      default: ;
    endcase
    send_op(op, a, b, SHIFT_W'($urandom_range(63)), ($urandom_range(9) < 7),
            COND_W'($urandom_range(15)));
  endtask

  initial begin
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.opcode       <= OP_ADD;
    req.operand_a    <= '0;
    req.operand_b    <= '0;
    req.wide_shift   <= '0;
    req.update_flags <= 1'b0;
    req.condition    <= COND_EQ;
    send_idle_pct  = 15;
    recv_stall_pct = 74;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_op(OP_ADD, ONES, 64'd1, 6'd0, 1'b1, COND_EQ);
    send_op(OP_ADD, MAX_POS, 64'd1, 6'd0, 1'b1, COND_VS);
    send_op(OP_ADD, MIN_WORD, MIN_WORD, 6'd0, 1'b1, COND_VC);
    send_op(OP_SUB, 64'd5, 64'd5, 6'd0, 1'b1, COND_CS);
    send_op(OP_SUB, 64'd0, 64'd1, 6'd0, 1'b1, COND_CC);
    send_op(OP_SUB, MIN_WORD, 64'd1, 6'd0, 1'b1, COND_GE);
    send_op(OP_SUB, MAX_POS, ONES, 6'd0, 1'b1, COND_LT);
    send_op(OP_ORN, 64'd0, ONES, 6'd0, 1'b1, COND_HI);
    send_op(OP_OR, MIN_WORD, 64'd1, 6'd0, 1'b0, COND_LS);
    send_op(OP_XOR, ONES, ONES, 6'd0, 1'b1, COND_GT);
    send_op(OP_AND, ONES, MIN_WORD, 6'd0, 1'b1, COND_LE);
    send_op(OP_MOVW, 64'd0, 64'hffff, 6'd48, 1'b1, COND_MI);
    send_op(OP_MOVW, 64'd1, ONES, 6'd63, 1'b1, COND_PL);
    send_op(OP_LSL, ONES, 64'd0, 6'd0, 1'b1, COND_NE);
    send_op(OP_LSL, MIN_WORD | 64'd1, 64'd1, 6'd0, 1'b1, COND_CS);
    send_op(OP_LSL, 64'd1, 64'd63, 6'd0, 1'b1, COND_MI);
    send_op(OP_LSR, MIN_WORD, 64'd0, 6'd0, 1'b1, COND_CC);
    send_op(OP_LSR, ONES, 64'd63, 6'd0, 1'b1, COND_HI);
    send_op(OP_LSR, ONES, 64'hffff_ffff_ffff_ffc1, 6'd0, 1'b1, COND_CS);
    send_op(OP_ASR, MIN_WORD, 64'd63, 6'd0, 1'b1, COND_MI);
    send_op(OP_ASR, MIN_WORD | 64'd1, 64'd1, 6'd0, 1'b1, COND_CS);
    send_op(OP_PASSA, 64'd0, ONES, 6'd0, 1'b1, COND_EQ);
    send_op(OP_UNUSED_LO, ONES, ONES, 6'd0, 1'b1, COND_NV);
    send_op(OP_UNUSED_HI, MIN_WORD, 64'd1, 6'd63, 1'b1, COND_AL);
    send_op(OP_PASSA, MIN_WORD, 64'd0, 6'd0, 1'b0, COND_NV);

    repeat (RAND_PER_PHASE) send_random();
    send_idle_pct  = 74;
    recv_stall_pct = 15;
    repeat (RAND_PER_PHASE) send_random();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (RAND_PER_PHASE) send_random();
    req.valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
